// File: hw/rtl/ctp_pkg.sv
package ctp_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] FIELD_DELIM_SLASH = 3'd3;
  localparam logic [2:0] FIELD_PREFIX      = 3'd4;
  localparam logic [2:0] FIELD_DONE        = 3'd5;

  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_EMPTY = 3'd6;

  localparam logic [8:0]  OCTET_MAX  = 9'd255;
  localparam logic [8:0]  PREFIX_MAX = 9'd32;
  localparam logic [12:0] ACCUM_SAT  = 13'd511;
  localparam logic [12:0] RADIX      = 13'd10;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]      field_index;
    logic [8:0]      digit_accum;
    logic            token_started;
    logic [2:0]      error_code;
    logic [3:0][7:0] octet_store;
    logic [5:0]      prefix_store;
    logic            string_ended;
    logic            any_char_seen;
  } ctp_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  octet_a;
    logic [7:0]  octet_b;
    logic [7:0]  octet_c;
    logic [7:0]  octet_d;
    logic [5:0]  prefix_len;
    logic [31:0] packed_addr;
    logic [31:0] net_mask;
  } ctp_result_t;

endpackage

// File: hw/rtl/ctp_step.sv
module ctp_step
  import ctp_pkg::*;
(
  input  ctp_state_t  state_i,
  input  logic [7:0]  char_code_i,
  output ctp_state_t  state_o,
  output ctp_result_t result_o
);

  function automatic ctp_state_t close_token(ctp_state_t s);
    logic [8:0] limit;
    limit = (s.field_index < FIELD_PREFIX) ? OCTET_MAX : PREFIX_MAX;
    if (s.digit_accum > limit) begin
      s.error_code = s.field_index + 3'd1;
    end else begin
      if (s.field_index < FIELD_PREFIX) begin
        s.octet_store[s.field_index[1:0]] = s.digit_accum[7:0];
      end else begin
        s.prefix_store = s.digit_accum[5:0];
      end
      s.field_index   = s.field_index + 3'd1;
      s.digit_accum   = '0;
      s.token_started = 1'b0;
    end
    return s;
  endfunction

  ctp_state_t  s;
  ctp_state_t  f;
  logic [7:0]  delim;
  logic [12:0] acc_ext;
  logic [2:0]  status;

  always_comb begin
    s       = state_i;
    delim   = CHAR_DOT;
    acc_ext = '0;
    if (!s.string_ended) begin
      if (char_code_i == CHAR_NUL) begin
        s.string_ended = 1'b1;
      end else begin
        s.any_char_seen = 1'b1;
        if (s.error_code == STATUS_OK && s.field_index < FIELD_DONE) begin
          delim = (s.field_index < FIELD_DELIM_SLASH) ? CHAR_DOT : CHAR_SLASH;
          if (char_code_i == delim) begin
            if (s.token_started) begin
              s = close_token(s);
            end
          end else if (char_code_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
            acc_ext = {4'd0, s.digit_accum} * RADIX
                    + {9'd0, char_code_i[3:0]};
            s.digit_accum   = (acc_ext > ACCUM_SAT) ? ACCUM_SAT[8:0] : acc_ext[8:0];
            s.token_started = 1'b1;
          end else begin
            s.error_code = s.field_index + 3'd1;
          end
        end
      end
    end
    state_o = s;
  end

  always_comb begin
    f = s;
    if (f.error_code == STATUS_OK && f.field_index < FIELD_DONE) begin
      if (f.token_started) begin
        f = close_token(f);
      end
      if (f.error_code == STATUS_OK && f.field_index < FIELD_DONE) begin
        f.error_code = f.field_index + 3'd1;
      end
    end
    status   = f.any_char_seen ? f.error_code : STATUS_EMPTY;
    result_o = '0;
    result_o.status = status;
    if (status == STATUS_OK) begin
      result_o.octet_a     = f.octet_store[0];
      result_o.octet_b     = f.octet_store[1];
      result_o.octet_c     = f.octet_store[2];
      result_o.octet_d     = f.octet_store[3];
      result_o.prefix_len  = f.prefix_store;
      result_o.packed_addr = f.octet_store;
      result_o.net_mask    = ~(ALL_ONES >> f.prefix_store);
    end
  end

endmodule

// File: hw/rtl/cidr_text_parser_top.sv
// Output: a result is registered and appears in the cycle after the request carrying last_char.
// Throughput: one character per cycle; a single parse register feeds the
// result register, stalled only while a result waits on out_ready_i.
// Reset: asynchronous active-low; clears parse state and the result valid.
// Parse state returns to reset after each last character.
module cidr_text_parser_top
  import ctp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  octet_a_o,
  output logic [7:0]  octet_b_o,
  output logic [7:0]  octet_c_o,
  output logic [7:0]  octet_d_o,
  output logic [5:0]  prefix_len_o,
  output logic [31:0] packed_addr_o,
  output logic [31:0] net_mask_o
);

  ctp_state_t  state_q, state_d, step_state;
  ctp_result_t result_q, step_result;
  logic        out_valid_q, out_valid_d;
  logic        in_fire;

  ctp_step u_step (
    .state_i     (state_q),
    .char_code_i (char_code_i),
    .state_o     (step_state),
    .result_o    (step_result)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire) begin
      state_d = last_char_i ? '0 : step_state;
      if (last_char_i) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_char_i) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = result_q.status;
  assign octet_a_o     = result_q.octet_a;
  assign octet_b_o     = result_q.octet_b;
  assign octet_c_o     = result_q.octet_c;
  assign octet_d_o     = result_q.octet_d;
  assign prefix_len_o  = result_q.prefix_len;
  assign packed_addr_o = result_q.packed_addr;
  assign net_mask_o    = result_q.net_mask;

endmodule
